/* src/host_power_sequencer_top_macros.svh */
// assertion macros shared by the host power sequencer modules
`ifndef HOST_POWER_SEQUENCER_TOP_MACROS_SVH
`define HOST_POWER_SEQUENCER_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define HPS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define HPS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* src/hps_pkg.sv */
// types, constants and helpers for the host power sequencer
`timescale 1ns / 1ps

package hps_pkg;

  // default counter width
  localparam int TIMER_WIDTH_DEF = 16;

  // configuration register geometry
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_WAIT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_POST_PULSE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAFE_OFF     = 3'd4;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] RELEASE_WAIT_RST = 16'd100;
  localparam logic [CFG_DATA_W-1:0] HOLDOFF_RST      = 16'd250;
  localparam logic [CFG_DATA_W-1:0] PULSE_RST        = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] POST_PULSE_RST   = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] SAFE_OFF_RST     = 16'd5000;

  // phases, one-hot, bit position equals the reported phase code
  localparam int NUM_PHASES = 13;

  typedef enum logic [NUM_PHASES-1:0] {
    PH_IDLE       = 13'h0001,
    PH_ON_REL     = 13'h0002,
    PH_ON_HOLD    = 13'h0004,
    PH_WAIT_READY = 13'h0008,
    PH_RUN        = 13'h0010,
    PH_OFF_REL    = 13'h0020,
    PH_OFF_HOLD   = 13'h0040,
    PH_RST_REL    = 13'h0080,
    PH_RST_HOLD   = 13'h0100,
    PH_PULSE      = 13'h0200,
    PH_POST_PULSE = 13'h0400,
    PH_WAIT_DOWN  = 13'h0800,
    PH_SAFE       = 13'h1000
  } hps_phase_t;

  // phases whose length is set by the down-counter
  localparam logic [NUM_PHASES-1:0] TIMED_MASK =
    PH_ON_REL | PH_ON_HOLD | PH_OFF_REL | PH_OFF_HOLD | PH_RST_REL |
    PH_RST_HOLD | PH_PULSE | PH_POST_PULSE | PH_SAFE;

  // timing registers as seen by the sequencer
  typedef struct packed {
    logic [CFG_DATA_W-1:0] release_wait;
    logic [CFG_DATA_W-1:0] holdoff;
    logic [CFG_DATA_W-1:0] pulse;
    logic [CFG_DATA_W-1:0] post_pulse;
    logic [CFG_DATA_W-1:0] safe_off;
  } hps_cfg_t;

  // one result item
  typedef struct packed {
    logic       relay_on;
    logic       line_driven;
    logic       line_level;
    logic [3:0] phase_code;
  } hps_result_t;

  // numeric phase code of a one-hot phase
  function automatic logic [3:0] phase_to_code(hps_phase_t p);
    logic [3:0] code;
    code = 4'd0;
    case (p)
      PH_IDLE:       code = 4'd0;
      PH_ON_REL:     code = 4'd1;
      PH_ON_HOLD:    code = 4'd2;
      PH_WAIT_READY: code = 4'd3;
      PH_RUN:        code = 4'd4;
      PH_OFF_REL:    code = 4'd5;
      PH_OFF_HOLD:   code = 4'd6;
      PH_RST_REL:    code = 4'd7;
      PH_RST_HOLD:   code = 4'd8;
      PH_PULSE:      code = 4'd9;
      PH_POST_PULSE: code = 4'd10;
      PH_WAIT_DOWN:  code = 4'd11;
      PH_SAFE:       code = 4'd12;
      default:       code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

/* src/hps_cfg_regs.sv */
// timing configuration registers of the host power sequencer
`timescale 1ns / 1ps

module hps_cfg_regs import hps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output hps_cfg_t               cfg
);

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.release_wait <= RELEASE_WAIT_RST;
      cfg.holdoff      <= HOLDOFF_RST;
      cfg.pulse        <= PULSE_RST;
      cfg.post_pulse   <= POST_PULSE_RST;
      cfg.safe_off     <= SAFE_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RELEASE_WAIT: cfg.release_wait <= cfg_data;
        CFG_HOLDOFF:      cfg.holdoff      <= cfg_data;
        CFG_PULSE:        cfg.pulse        <= cfg_data;
        CFG_POST_PULSE:   cfg.post_pulse   <= cfg_data;
        CFG_SAFE_OFF:     cfg.safe_off     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/hps_seq_core.sv */
// phase state machine and down-counter, one update per accepted tick
`timescale 1ns / 1ps

module hps_seq_core import hps_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        on_off_level,
  input  logic        reset_level,
  input  logic        host_ready,
  input  hps_cfg_t    cfg,
  output hps_result_t result_next
);

  `include "host_power_sequencer_top_macros.svh"

  hps_phase_t             phase, phase_next;
  logic [TIMER_WIDTH-1:0] countdown, countdown_next;
  logic                   relay_state, relay_state_next;

  logic on_low, rst_low, timed;

  assign on_low  = !on_off_level;
  assign rst_low = !reset_level;
  assign timed   = |(phase & TIMED_MASK);

  // next phase, counter and relay for this tick
  always_comb begin
    phase_next       = phase;
    countdown_next   = countdown;
    relay_state_next = relay_state;
    if (timed && (countdown != '0)) begin
      countdown_next = countdown - TIMER_WIDTH'(1);
    end else begin
      case (phase)
        PH_IDLE: begin
          if (on_low) begin
            phase_next     = PH_ON_REL;
            countdown_next = TIMER_WIDTH'(cfg.release_wait);
          end
        end
        PH_ON_REL: begin
          if (!on_low) begin
            phase_next     = PH_ON_HOLD;
            countdown_next = TIMER_WIDTH'(cfg.holdoff);
          end else begin
            phase_next     = PH_IDLE;
            countdown_next = '0;
          end
        end
        PH_ON_HOLD: begin
          relay_state_next = 1'b1;
          phase_next       = PH_WAIT_READY;
          countdown_next   = '0;
        end
        PH_WAIT_READY: begin
          if (host_ready) begin
            phase_next     = PH_RUN;
            countdown_next = '0;
          end
        end
        PH_RUN: begin
          if (on_low) begin
            phase_next     = PH_OFF_REL;
            countdown_next = TIMER_WIDTH'(cfg.release_wait);
          end else if (rst_low) begin
            phase_next     = PH_RST_REL;
            countdown_next = TIMER_WIDTH'(cfg.release_wait);
          end
        end
        PH_OFF_REL: begin
          if (!on_low) begin
            phase_next     = PH_OFF_HOLD;
            countdown_next = TIMER_WIDTH'(cfg.holdoff);
          end else if (rst_low) begin
            phase_next     = PH_RST_REL;
            countdown_next = TIMER_WIDTH'(cfg.release_wait);
          end else begin
            phase_next     = PH_RUN;
            countdown_next = '0;
          end
        end
        PH_OFF_HOLD: begin
          phase_next     = PH_PULSE;
          countdown_next = TIMER_WIDTH'(cfg.pulse);
        end
        PH_RST_REL: begin
          if (!rst_low) begin
            phase_next     = PH_RST_HOLD;
            countdown_next = TIMER_WIDTH'(cfg.holdoff);
          end else begin
            phase_next     = PH_RUN;
            countdown_next = '0;
          end
        end
        PH_RST_HOLD: begin
          relay_state_next = 1'b0;
          phase_next       = PH_IDLE;
          countdown_next   = '0;
        end
        PH_PULSE: begin
          phase_next     = PH_POST_PULSE;
          countdown_next = TIMER_WIDTH'(cfg.post_pulse);
        end
        PH_POST_PULSE: begin
          phase_next     = PH_WAIT_DOWN;
          countdown_next = '0;
        end
        PH_WAIT_DOWN: begin
          if (!host_ready) begin
            phase_next     = PH_SAFE;
            countdown_next = TIMER_WIDTH'(cfg.safe_off);
          end
        end
        PH_SAFE: begin
          relay_state_next = 1'b0;
          phase_next       = PH_IDLE;
          countdown_next   = '0;
        end
        default: begin
          relay_state_next = 1'b0;
          phase_next       = PH_IDLE;
          countdown_next   = '0;
        end
      endcase
    end
  end

  // state registers, advanced on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      countdown   <= '0;
      relay_state <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      countdown   <= countdown_next;
      relay_state <= relay_state_next;
    end
  end

  // result from the state after the update
  always_comb begin
    result_next.relay_on    = relay_state_next;
    result_next.line_driven = (phase_next == PH_PULSE);
    result_next.line_level  = (phase_next == PH_PULSE);
    result_next.phase_code  = phase_to_code(phase_next);
  end

  `HPS_CHECK(a_relay_rise, $rose(relay_state) |-> ($past(phase) == PH_ON_HOLD), "relay rose outside on hold-off")
  `HPS_NEVER(a_idle_count, !timed && (countdown != '0), "counter loaded in an untimed phase")
  `HPS_NEVER(a_run_relay, (phase == PH_RUN) && !relay_state, "running with relay off")

endmodule

/* src/hps_out_buffer.sv */
// two-entry result buffer: output register plus skid stage
`timescale 1ns / 1ps

module hps_out_buffer import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  hps_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output hps_result_t out_data
);

  `include "host_power_sequencer_top_macros.svh"

  logic        skid_valid;
  hps_result_t skid_data;
  logic        pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  `HPS_NEVER(a_skid_alone, skid_valid && !out_valid, "skid entry without head entry")
  `HPS_CHECK(a_head_holds, (out_valid && !out_ready) |=> out_valid, "pending result dropped")
  `HPS_CHECK(a_skid_order, (skid_valid && pop) |=> (out_valid && !skid_valid), "skid entry lost")

endmodule

/* src/host_power_sequencer_top.sv */
// Host power sequencer. Each input transfer is one millisecond tick with the
// sampled on/off button, reset button and host-ready line; each tick yields
// exactly one result with the relay, host-line drive and phase code. A tick
// is taken every cycle while the buffer has room: the phase machine and
// down-counter update in one pass and the result is registered. A two-entry
// result buffer lets ticks keep flowing while a result waits; input stalls
// only when both entries are full. The user must write the timing registers
// through the cfg port only while the block is idle; the block never checks.
`timescale 1ns / 1ps

module host_power_sequencer_top import hps_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   on_off_level,
  input  logic                   reset_level,
  input  logic                   host_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   relay_on,
  output logic                   line_driven,
  output logic                   line_level,
  output logic [3:0]             phase_code
);

  hps_cfg_t    cfg;
  hps_result_t result_next;
  hps_result_t out_data;
  logic        step;

  // tick transfer
  assign step = in_valid && in_ready;

  hps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hps_seq_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .on_off_level (on_off_level),
    .reset_level  (reset_level),
    .host_ready   (host_ready),
    .cfg          (cfg),
    .result_next  (result_next)
  );

  hps_out_buffer u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (result_next),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // result fields
  assign relay_on    = out_data.relay_on;
  assign line_driven = out_data.line_driven;
  assign line_level  = out_data.line_level;
  assign phase_code  = out_data.phase_code;

endmodule
